// ----- src/subband_adpcm_speech_decoder_assert.svh -----
// assertion macros shared by the checker of the sub-band decoder
// expects signals named clk and rst_n in the scope of use
`ifndef SUBBAND_ADPCM_SPEECH_DECODER_ASSERT_SVH
`define SUBBAND_ADPCM_SPEECH_DECODER_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define SAD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sad assertion failed");

// consequent must hold in the same cycle as the antecedent
`define SAD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sad assertion failed");

`endif

// ----- src/sad_pkg.sv -----
// types, constant tables and saturating helpers for the sub-band adpcm decoder
// no dependencies; used by sad_ctrl, sad_dp and the top level
package sad_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } ctl_state_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_RL,
        OP_DQ,
        OP_NB,
        OP_DET1,
        OP_DET2,
        OP_PH,
        OP_ZC,
        OP_A2,
        OP_A1,
        OP_SZ,
        OP_P1,
        OP_P2,
        OP_SE,
        OP_QLOAD,
        OP_QMAC,
        OP_QOUT,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       band;
        logic [4:0] idx;
    } cmd_t;

    localparam int BAND_STEPS = 23;
    localparam int QLOAD_PC   = 2 * BAND_STEPS;
    localparam int QMAC_PC    = QLOAD_PC + 1;
    localparam int QMF_TAPS_N = 24;
    localparam int QOUT_PC    = QMAC_PC + QMF_TAPS_N;
    localparam int PROG_LAST  = QOUT_PC;

    localparam logic [14:0] LOW_NB_MAX  = 15'd18432;
    localparam logic [14:0] HIGH_NB_MAX = 15'd22528;
    localparam logic [9:0]  LOW_OFFSET  = 10'd64;
    localparam logic [8:0]  ALOG_LAST   = 9'd352;
    localparam logic signed [15:0] LEAK_POLE2 = 16'sd32512;
    localparam logic signed [15:0] LEAK_ZERO  = 16'sd32640;
    localparam logic signed [15:0] A2_LIMIT   = 16'sd12288;
    localparam logic signed [15:0] A1_BOUND   = 16'sd15360;

    localparam logic signed [15:0] QMF_TAPS [QMF_TAPS_N] = '{
        16'sd6, -16'sd22, -16'sd22, 16'sd106, 16'sd24, -16'sd312, 16'sd64, 16'sd724,
        -16'sd420, -16'sd1610, 16'sd1902, 16'sd7752, 16'sd7752, 16'sd1902, -16'sd1610,
        -16'sd420, 16'sd724, 16'sd64, -16'sd312, 16'sd24, 16'sd106, -16'sd22,
        -16'sd22, 16'sd6
    };

    localparam logic [11:0] LVL4 [8] = '{
        12'd0, 12'd150, 12'd323, 12'd530, 12'd786, 12'd1121, 12'd1612, 12'd2557
    };
    localparam logic [2:0] IDX4 [16] = '{
        3'd0, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1,
        3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
    };
    localparam logic [4:0] IDX6 [64] = '{
        5'd1, 5'd1, 5'd1, 5'd1, 5'd30, 5'd29, 5'd28, 5'd27, 5'd26, 5'd25, 5'd24,
        5'd23, 5'd22, 5'd21, 5'd20, 5'd19, 5'd18, 5'd17, 5'd16, 5'd15, 5'd14,
        5'd13, 5'd12, 5'd11, 5'd10, 5'd9, 5'd8, 5'd7, 5'd6, 5'd5, 5'd4, 5'd3,
        5'd30, 5'd29, 5'd28, 5'd27, 5'd26, 5'd25, 5'd24, 5'd23, 5'd22, 5'd21,
        5'd20, 5'd19, 5'd18, 5'd17, 5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd11,
        5'd10, 5'd9, 5'd8, 5'd7, 5'd6, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1, 5'd2, 5'd1
    };
    localparam logic [11:0] LVL6 [31] = '{
        12'd0, 12'd17, 12'd54, 12'd91, 12'd130, 12'd170, 12'd211, 12'd254,
        12'd300, 12'd347, 12'd396, 12'd447, 12'd501, 12'd558, 12'd618, 12'd682,
        12'd750, 12'd822, 12'd899, 12'd982, 12'd1072, 12'd1170, 12'd1279,
        12'd1399, 12'd1535, 12'd1689, 12'd1873, 12'd2088, 12'd2376, 12'd2738,
        12'd3101
    };
    localparam logic [11:0] LVL2 [3] = '{12'd0, 12'd202, 12'd926};
    localparam logic signed [15:0] HSTEP [3] = '{16'sd0, -16'sd214, 16'sd798};
    localparam logic signed [15:0] LSTEP [8] = '{
        -16'sd60, -16'sd30, 16'sd58, 16'sd172, 16'sd334, 16'sd538, 16'sd1198, 16'sd3042
    };

    localparam logic [11:0] ANTILOG [353] = '{
        12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1,
        12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd2,
        12'd2, 12'd2, 12'd2, 12'd2, 12'd2, 12'd2, 12'd2, 12'd2, 12'd2, 12'd2,
        12'd2, 12'd2, 12'd3, 12'd3, 12'd3, 12'd3, 12'd3, 12'd3, 12'd3, 12'd3,
        12'd3, 12'd3, 12'd3, 12'd4, 12'd4, 12'd4, 12'd4, 12'd4, 12'd4, 12'd4,
        12'd4, 12'd5, 12'd5, 12'd5, 12'd5, 12'd5, 12'd5, 12'd5, 12'd6, 12'd6,
        12'd6, 12'd6, 12'd6, 12'd6, 12'd7, 12'd7, 12'd7, 12'd7, 12'd7, 12'd7,
        12'd8, 12'd8, 12'd8, 12'd8, 12'd8, 12'd9, 12'd9, 12'd9, 12'd9, 12'd10,
        12'd10, 12'd10, 12'd10, 12'd11, 12'd11, 12'd11, 12'd11, 12'd12, 12'd12,
        12'd12, 12'd13, 12'd13, 12'd13, 12'd13, 12'd14, 12'd14, 12'd15, 12'd15,
        12'd15, 12'd16, 12'd16, 12'd16, 12'd17, 12'd17, 12'd18, 12'd18, 12'd18,
        12'd19, 12'd19, 12'd20, 12'd20, 12'd21, 12'd21, 12'd22, 12'd22, 12'd23,
        12'd23, 12'd24, 12'd24, 12'd25, 12'd25, 12'd26, 12'd27, 12'd27, 12'd28,
        12'd28, 12'd29, 12'd30, 12'd31, 12'd31, 12'd32, 12'd33, 12'd33, 12'd34,
        12'd35, 12'd36, 12'd37, 12'd37, 12'd38, 12'd39, 12'd40, 12'd41, 12'd42,
        12'd43, 12'd44, 12'd45, 12'd46, 12'd47, 12'd48, 12'd49, 12'd50, 12'd51,
        12'd52, 12'd54, 12'd55, 12'd56, 12'd57, 12'd58, 12'd60, 12'd61, 12'd63,
        12'd64, 12'd65, 12'd67, 12'd68, 12'd70, 12'd71, 12'd73, 12'd75, 12'd76,
        12'd78, 12'd80, 12'd82, 12'd83, 12'd85, 12'd87, 12'd89, 12'd91, 12'd93,
        12'd95, 12'd97, 12'd99, 12'd102, 12'd104, 12'd106, 12'd109, 12'd111,
        12'd113, 12'd116, 12'd118, 12'd121, 12'd124, 12'd127, 12'd129, 12'd132,
        12'd135, 12'd138, 12'd141, 12'd144, 12'd147, 12'd151, 12'd154, 12'd157,
        12'd161, 12'd165, 12'd168, 12'd172, 12'd176, 12'd180, 12'd184, 12'd188,
        12'd192, 12'd196, 12'd200, 12'd205, 12'd209, 12'd214, 12'd219, 12'd223,
        12'd228, 12'd233, 12'd238, 12'd244, 12'd249, 12'd255, 12'd260, 12'd266,
        12'd272, 12'd278, 12'd284, 12'd290, 12'd296, 12'd303, 12'd310, 12'd316,
        12'd323, 12'd331, 12'd338, 12'd345, 12'd353, 12'd361, 12'd369, 12'd377,
        12'd385, 12'd393, 12'd402, 12'd411, 12'd420, 12'd429, 12'd439, 12'd448,
        12'd458, 12'd468, 12'd478, 12'd489, 12'd500, 12'd511, 12'd522, 12'd533,
        12'd545, 12'd557, 12'd569, 12'd582, 12'd594, 12'd607, 12'd621, 12'd634,
        12'd648, 12'd663, 12'd677, 12'd692, 12'd707, 12'd723, 12'd739, 12'd755,
        12'd771, 12'd788, 12'd806, 12'd823, 12'd841, 12'd860, 12'd879, 12'd898,
        12'd918, 12'd938, 12'd958, 12'd979, 12'd1001, 12'd1023, 12'd1045,
        12'd1068, 12'd1092, 12'd1115, 12'd1140, 12'd1165, 12'd1190, 12'd1216,
        12'd1243, 12'd1270, 12'd1298, 12'd1327, 12'd1356, 12'd1386, 12'd1416,
        12'd1447, 12'd1479, 12'd1511, 12'd1544, 12'd1578, 12'd1613, 12'd1648,
        12'd1684, 12'd1721, 12'd1759, 12'd1797, 12'd1837, 12'd1877, 12'd1918,
        12'd1960, 12'd2003, 12'd2047, 12'd2092, 12'd2138, 12'd2185, 12'd2232,
        12'd2281, 12'd2331, 12'd2382, 12'd2434, 12'd2488, 12'd2542, 12'd2598,
        12'd2655, 12'd2713, 12'd2773, 12'd2833, 12'd2895, 12'd2959, 12'd3024,
        12'd3090, 12'd3157, 12'd3227, 12'd3297, 12'd3370, 12'd3443, 12'd3519,
        12'd3596, 12'd3675, 12'd3755, 12'd3837, 12'd3921, 12'd4007, 12'd4095
    };

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        logic signed [15:0] r;
        if (v > 34'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -34'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] add16(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
        return sat16(34'(a) + 34'(b));
    endfunction

    function automatic logic signed [15:0] lim14(input logic signed [15:0] v);
        logic signed [15:0] r;
        if (v > 16'sd16383) begin
            r = 16'sd16383;
        end else if (v < -16'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // signed quantizer level scaled by 8
    function automatic logic signed [15:0] level_word(input logic [11:0] mag,
                                                      input logic neg);
        logic signed [15:0] w;
        w = signed'({1'b0, mag, 3'b000});
        return neg ? -w : w;
    endfunction

    // step sequence of one code word, both bands then the qmf
    function automatic cmd_t prog_cmd(input logic [6:0] pc);
        cmd_t c;
        logic [6:0] s;
        c.op   = OP_NOP;
        c.band = 1'b0;
        c.idx  = '0;
        s      = '0;
        if (pc < 7'(QLOAD_PC)) begin
            c.band = (pc >= 7'(BAND_STEPS));
            s = c.band ? pc - 7'(BAND_STEPS) : pc;
            priority if (s == 7'd0) c.op = OP_RL;
            else if (s == 7'd1) c.op = OP_DQ;
            else if (s == 7'd2) c.op = OP_NB;
            else if (s == 7'd3) c.op = OP_DET1;
            else if (s == 7'd4) c.op = OP_DET2;
            else if (s == 7'd5) c.op = OP_PH;
            else if (s <= 7'd11) begin
                c.op  = OP_ZC;
                c.idx = 5'(s - 7'd6);
            end
            else if (s == 7'd12) c.op = OP_A2;
            else if (s == 7'd13) c.op = OP_A1;
            else if (s <= 7'd19) begin
                // zero section sums from the oldest tap down
                c.op  = OP_SZ;
                c.idx = 5'(7'd19 - s);
            end
            else if (s == 7'd20) c.op = OP_P1;
            else if (s == 7'd21) c.op = OP_P2;
            else c.op = OP_SE;
        end else if (pc == 7'(QLOAD_PC)) begin
            c.op = OP_QLOAD;
        end else if (pc < 7'(QOUT_PC)) begin
            c.op  = OP_QMAC;
            c.idx = 5'(pc - 7'(QMAC_PC));
        end else begin
            c.op = OP_QOUT;
        end
        return c;
    endfunction

endpackage

// ----- src/sad_dp.sv -----
// datapath: per-band predictor state, qmf delay line, one shared 16x16 multiplier
// depends on sad_pkg; driven by commands from sad_ctrl
module sad_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  sad_pkg::cmd_t       cmd,
    input  logic [7:0]          code_octet,
    output logic signed [15:0]  sample_first,
    output logic signed [15:0]  sample_second
);

    logic signed [15:0] dh_reg   [2][7];
    logic signed [15:0] zc_reg   [2][6];
    logic signed [15:0] pole_reg [2][2];
    logic signed [15:0] ph_reg   [2][3];
    logic signed [15:0] rh_reg   [2][3];
    logic signed [15:0] zest_reg [2];
    logic signed [15:0] pest_reg [2];
    logic signed [15:0] sest_reg [2];
    logic [14:0]        nbl_reg  [2];
    logic signed [15:0] det_reg  [2];
    logic signed [15:0] qd_reg   [sad_pkg::QMF_TAPS_N];
    logic signed [31:0] acc_reg  [2];
    logic [7:0]         code_reg;
    logic signed [15:0] rl_reg;
    logic [11:0]        alog_reg;
    logic signed [15:0] res_first_reg;
    logic signed [15:0] res_second_reg;

    logic               b;
    logic [2:0]         kz;
    logic [2:0]         kz1;
    logic [4:0]         kq;
    logic [5:0]         lc;
    logic [1:0]         hc;
    logic [3:0]         q;
    logic signed [15:0] w6;
    logic signed [15:0] wdq;
    logic signed [15:0] stepv;
    logic signed [15:0] ma;
    logic signed [15:0] mb;
    logic signed [31:0] prod;
    logic signed [31:0] prod_sh;
    logic signed [15:0] m16;
    logic signed [15:0] nb_sum;
    logic [14:0]        nb_max;
    logic [14:0]        nb_clamped;
    logic [9:0]         ksum;
    logic [8:0]         kidx;
    logic [12:0]        alog_inc;
    logic signed [15:0] zstep;
    logic signed [15:0] zw;
    logic               p0;
    logic               p1;
    logic               p2;
    logic signed [15:0] w1;
    logic signed [15:0] w2;
    logic signed [15:0] a2_raw;
    logic signed [15:0] a2;
    logic signed [15:0] a1_raw;
    logic signed [15:0] a1;
    logic signed [15:0] bound;
    logic signed [15:0] rhs;
    logic signed [32:0] mac_sum;
    logic signed [31:0] mac_sat;

    assign b   = cmd.band;
    assign kz  = cmd.idx[2:0];
    assign kz1 = kz + 3'd1;
    assign kq  = cmd.idx;
    assign lc  = code_reg[5:0];
    assign hc  = code_reg[7:6];
    assign q   = lc[5:2];

    assign w6 = sad_pkg::level_word(sad_pkg::LVL6[sad_pkg::IDX6[lc]],
                                    (lc < 6'd32) || (lc >= 6'd62));

    always_comb
    begin
        if (b) begin
            wdq   = sad_pkg::level_word(sad_pkg::LVL2[hc[0] ? 2'd1 : 2'd2], !hc[1]);
            stepv = sad_pkg::HSTEP[hc[0] ? 2'd1 : 2'd2];
        end else begin
            wdq   = sad_pkg::level_word(sad_pkg::LVL4[sad_pkg::IDX4[q]], !q[3]);
            stepv = sad_pkg::LSTEP[sad_pkg::IDX4[q]];
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (cmd.op)
            sad_pkg::OP_RL:
            begin
                ma = det_reg[0];
                mb = w6;
            end
            sad_pkg::OP_DQ:
            begin
                ma = det_reg[b];
                mb = wdq;
            end
            sad_pkg::OP_NB:
            begin
                ma = signed'({1'b0, nbl_reg[b]});
                mb = sad_pkg::LEAK_POLE2;
            end
            sad_pkg::OP_ZC:
            begin
                ma = zc_reg[b][kz];
                mb = sad_pkg::LEAK_ZERO;
            end
            sad_pkg::OP_A2:
            begin
                ma = pole_reg[b][1];
                mb = sad_pkg::LEAK_POLE2;
            end
            sad_pkg::OP_A1:
            begin
                ma = pole_reg[b][0];
                mb = sad_pkg::LEAK_ZERO;
            end
            sad_pkg::OP_SZ:
            begin
                ma = sad_pkg::add16(dh_reg[b][kz1], dh_reg[b][kz1]);
                mb = zc_reg[b][kz];
            end
            sad_pkg::OP_P1:
            begin
                ma = pole_reg[b][0];
                mb = sad_pkg::add16(rh_reg[b][1], rh_reg[b][1]);
            end
            sad_pkg::OP_P2:
            begin
                ma = pole_reg[b][1];
                mb = sad_pkg::add16(rh_reg[b][2], rh_reg[b][2]);
            end
            sad_pkg::OP_QMAC:
            begin
                ma = sad_pkg::QMF_TAPS[kq];
                mb = qd_reg[kq];
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod    = ma * mb;
    assign prod_sh = prod >>> 15;
    assign m16     = sad_pkg::sat16(34'(prod_sh));

    // log scale update and scale factor index
    assign nb_sum = sad_pkg::add16(m16, stepv);
    assign nb_max = b ? sad_pkg::HIGH_NB_MAX : sad_pkg::LOW_NB_MAX;
    always_comb
    begin
        priority if (nb_sum[15]) nb_clamped = '0;
        else if (nb_sum[14:0] > nb_max) nb_clamped = nb_max;
        else nb_clamped = nb_sum[14:0];
    end
    assign ksum     = {1'b0, nbl_reg[b][14:6]} + (b ? 10'd0 : sad_pkg::LOW_OFFSET);
    assign kidx     = (ksum > 10'(sad_pkg::ALOG_LAST)) ? sad_pkg::ALOG_LAST : ksum[8:0];
    assign alog_inc = {1'b0, alog_reg} + 13'd1;

    // zero coefficient sign-sign update
    assign zstep = (dh_reg[b][0] == 16'sd0) ? 16'sd0 : 16'sd128;
    assign zw    = (dh_reg[b][0][15] == dh_reg[b][kz1][15]) ? zstep : -zstep;

    // pole coefficient update
    assign p0 = ph_reg[b][0][15];
    assign p1 = ph_reg[b][1][15];
    assign p2 = ph_reg[b][2][15];
    assign w1 = sad_pkg::sat16(34'(pole_reg[b][0]) <<< 2);
    assign w2 = (p0 == p1) ? sad_pkg::sat16(-34'(w1)) : w1;
    assign a2_raw = sad_pkg::add16(sad_pkg::add16(w2 >>> 7, (p0 == p2) ? 16'sd128 : -16'sd128),
                                   m16);
    always_comb
    begin
        priority if (a2_raw > sad_pkg::A2_LIMIT) a2 = sad_pkg::A2_LIMIT;
        else if (a2_raw < -sad_pkg::A2_LIMIT) a2 = -sad_pkg::A2_LIMIT;
        else a2 = a2_raw;
    end
    assign a1_raw = sad_pkg::add16((p0 == p1) ? 16'sd192 : -16'sd192, m16);
    assign bound  = sad_pkg::sat16(34'(sad_pkg::A1_BOUND) - 34'(pole_reg[b][1]));
    always_comb
    begin
        priority if (a1_raw > bound) a1 = bound;
        else if (a1_raw < -bound) a1 = -bound;
        else a1 = a1_raw;
    end

    // qmf
    assign rhs     = sad_pkg::lim14(rh_reg[1][0]);
    assign mac_sum = 33'(acc_reg[kq[0]]) + 33'(prod);
    always_comb
    begin
        priority if (mac_sum > 33'sh0_7FFF_FFFF) mac_sat = 32'sh7FFF_FFFF;
        else if (mac_sum < -33'sh0_8000_0000) mac_sat = 32'sh8000_0000;
        else mac_sat = mac_sum[31:0];
    end

    // acc * 16 saturated to 32 bits, upper half kept
    function automatic logic signed [15:0] qmf_out(input logic signed [31:0] acc);
        logic signed [35:0] v;
        logic signed [15:0] r;
        v = 36'(acc) <<< 4;
        if (v > 36'sh0_7FFF_FFFF) begin
            r = 16'sh7FFF;
        end else if (v < -36'sh0_8000_0000) begin
            r = 16'sh8000;
        end else begin
            r = v[31:16];
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 2; i++) begin
                for (int j = 0; j < 7; j++) dh_reg[i][j] <= '0;
                for (int j = 0; j < 6; j++) zc_reg[i][j] <= '0;
                for (int j = 0; j < 3; j++) begin
                    ph_reg[i][j] <= '0;
                    rh_reg[i][j] <= '0;
                end
                pole_reg[i][0] <= '0;
                pole_reg[i][1] <= '0;
                zest_reg[i]    <= '0;
                pest_reg[i]    <= '0;
                sest_reg[i]    <= '0;
                nbl_reg[i]     <= '0;
                acc_reg[i]     <= '0;
            end
            det_reg[0] <= 16'sd32;
            det_reg[1] <= 16'sd8;
            for (int j = 0; j < sad_pkg::QMF_TAPS_N; j++) qd_reg[j] <= '0;
            code_reg       <= '0;
            rl_reg         <= '0;
            alog_reg       <= '0;
            res_first_reg  <= '0;
            res_second_reg <= '0;
            sample_first   <= '0;
            sample_second  <= '0;
        end else begin
            unique case (cmd.op)
                sad_pkg::OP_LATCH: code_reg <= code_octet;
                sad_pkg::OP_RL:    rl_reg <= sad_pkg::lim14(sad_pkg::add16(sest_reg[0], m16));
                sad_pkg::OP_DQ:    dh_reg[b][0] <= m16;
                sad_pkg::OP_NB:    nbl_reg[b] <= nb_clamped;
                sad_pkg::OP_DET1:  alog_reg <= sad_pkg::ANTILOG[kidx];
                sad_pkg::OP_DET2:  det_reg[b] <= signed'({1'b0, alog_inc, 2'b00});
                sad_pkg::OP_PH:
                begin
                    ph_reg[b][0] <= sad_pkg::add16(dh_reg[b][0], zest_reg[b]);
                    rh_reg[b][0] <= sad_pkg::add16(sest_reg[b], dh_reg[b][0]);
                end
                sad_pkg::OP_ZC:    zc_reg[b][kz] <= sad_pkg::add16(zw, m16);
                sad_pkg::OP_A2:
                begin
                    pole_reg[b][1] <= a2;
                    for (int j = 6; j > 0; j--) dh_reg[b][j] <= dh_reg[b][j - 1];
                end
                sad_pkg::OP_A1:
                begin
                    pole_reg[b][0] <= a1;
                    ph_reg[b][2]   <= ph_reg[b][1];
                    ph_reg[b][1]   <= ph_reg[b][0];
                    rh_reg[b][2]   <= rh_reg[b][1];
                    rh_reg[b][1]   <= rh_reg[b][0];
                end
                sad_pkg::OP_SZ:
                    zest_reg[b] <= sad_pkg::add16((kz == 3'd5) ? 16'sd0 : zest_reg[b], m16);
                sad_pkg::OP_P1:    pest_reg[b] <= m16;
                sad_pkg::OP_P2:    pest_reg[b] <= sad_pkg::add16(pest_reg[b], m16);
                sad_pkg::OP_SE:    sest_reg[b] <= sad_pkg::add16(pest_reg[b], zest_reg[b]);
                sad_pkg::OP_QLOAD:
                begin
                    qd_reg[1]  <= sad_pkg::add16(rl_reg, rhs);
                    qd_reg[0]  <= sad_pkg::sat16(34'(rl_reg) - 34'(rhs));
                    acc_reg[0] <= '0;
                    acc_reg[1] <= '0;
                end
                sad_pkg::OP_QMAC:  acc_reg[kq[0]] <= mac_sat;
                sad_pkg::OP_QOUT:
                begin
                    res_first_reg  <= qmf_out(acc_reg[0]);
                    res_second_reg <= qmf_out(acc_reg[1]);
                    for (int j = sad_pkg::QMF_TAPS_N - 1; j >= 2; j--) qd_reg[j] <= qd_reg[j - 2];
                end
                sad_pkg::OP_EMIT:
                begin
                    sample_first  <= res_first_reg;
                    sample_second <= res_second_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ----- src/sad_ctrl.sv -----
// controller: handshake, step counter and command sequence for the datapath
// depends on sad_pkg
module sad_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          code_valid,
    output logic          code_stall,
    output logic          sample_valid,
    input  logic          sample_stall,
    output sad_pkg::cmd_t cmd
);

    sad_pkg::ctl_state_t state_reg;
    sad_pkg::ctl_state_t state_next;
    logic [6:0]          pc_reg;
    logic [6:0]          pc_next;
    logic                slot_free;
    logic                last_step;

    assign slot_free = !sample_valid || !sample_stall;
    assign last_step = (pc_reg == 7'(sad_pkg::PROG_LAST));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sad_pkg::ST_IDLE: if (code_valid) state_next = sad_pkg::ST_RUN;
            sad_pkg::ST_RUN:  if (last_step) state_next = sad_pkg::ST_DONE;
            sad_pkg::ST_DONE: if (slot_free) state_next = sad_pkg::ST_IDLE;
            default:          state_next = sad_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        code_stall = 1'b1;
        cmd        = '{op: sad_pkg::OP_NOP, band: 1'b0, idx: 5'd0};
        pc_next    = pc_reg;
        unique case (state_reg)
            sad_pkg::ST_IDLE:
            begin
                code_stall = 1'b0;
                pc_next    = '0;
                if (code_valid) cmd.op = sad_pkg::OP_LATCH;
            end
            sad_pkg::ST_RUN:
            begin
                cmd     = sad_pkg::prog_cmd(pc_reg);
                // the low-band reconstruction slot idles in the high band
                if ((cmd.op == sad_pkg::OP_RL) && cmd.band) cmd.op = sad_pkg::OP_NOP;
                pc_next = pc_reg + 7'd1;
            end
            sad_pkg::ST_DONE:
            begin
                if (slot_free) cmd.op = sad_pkg::OP_EMIT;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= sad_pkg::ST_IDLE;
            pc_reg       <= '0;
            sample_valid <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            if (cmd.op == sad_pkg::OP_EMIT) begin
                sample_valid <= 1'b1;
            end else if (!sample_stall) begin
                sample_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- src/subband_adpcm_speech_decoder.sv -----
// Sub-band adpcm speech decoder, 64 kbit/s mode 1. Each accepted beat on the code
// channel carries one 8-bit code word and yields one beat on the sample channel with
// two 16-bit pcm samples. Between one acceptance and the next, the code word is
// latched, the 72 steps of the command sequence run (23 per sub-band, a qmf load,
// 24 qmf taps and a final scaling step), and the result moves to the output register.
// The length of the sequence is set by the single shared 16x16 multiplier
// that every predictor, scale and qmf product goes through, one product per cycle.
// A finished result waits in the output register while the next code word is taken.
// depends on sad_pkg, sad_ctrl and sad_dp
module subband_adpcm_speech_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               code_valid,
    output logic               code_stall,
    input  logic [7:0]         code_octet,
    output logic               sample_valid,
    input  logic               sample_stall,
    output logic signed [15:0] sample_first,
    output logic signed [15:0] sample_second
);

    sad_pkg::cmd_t cmd;

    sad_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .code_valid   (code_valid),
        .code_stall   (code_stall),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .cmd          (cmd)
    );

    sad_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .code_octet    (code_octet),
        .sample_first  (sample_first),
        .sample_second (sample_second)
    );

endmodule

// ----- src/sad_checker.sv -----
// port-level checks for the sub-band decoder, attached by bind
// depends on subband_adpcm_speech_decoder_assert.svh
`include "subband_adpcm_speech_decoder_assert.svh"

module sad_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               code_valid,
    input logic               code_stall,
    input logic               sample_valid,
    input logic               sample_stall,
    input logic signed [15:0] sample_first,
    input logic signed [15:0] sample_second
);

    // result beat held while stalled
    `SAD_ASSERT_NEXT(a_out_hold, sample_valid && sample_stall, sample_valid)
    `SAD_ASSERT_NEXT(a_out_stable, sample_valid && sample_stall, $stable(sample_first) && $stable(sample_second))
    // an accepted code word keeps the block busy
    `SAD_ASSERT_NEXT(a_busy_after_accept, code_valid && !code_stall, code_stall && !$rose(sample_valid))
    // results appear only as the block goes idle again
    `SAD_ASSERT_NOW(a_rise_when_idle, $rose(sample_valid), !code_stall)

endmodule

bind subband_adpcm_speech_decoder sad_checker u_sad_checker (.*);
